FILE: hdl/swat_pkg.sv
// Shared types, sizes and helpers of the send window ack tracker.
// No dependencies; every other design file but swat_ram refers to it by scoped names.
package swat_pkg;

	localparam int SEQ_MODULUS = 30720;
	localparam int QUEUE_DEPTH = 16;

	localparam int SEQ_W     = 16;
	localparam int LEN_W     = 16;
	localparam int CWND_W    = 16;
	localparam int SUM_W     = SEQ_W + 1;
	localparam int ENTRIES_W = 5;
	localparam int ENTRY_W   = 2 * SEQ_W;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	// Remainder by shifted-modulus subtraction, one shift position a cycle
	localparam int MOD_BITS = $clog2(SEQ_MODULUS);
	localparam int K_MAX    = SUM_W - MOD_BITS;
	localparam int K_W      = (K_MAX > 0) ? $clog2(K_MAX + 1) : 1;

	localparam logic [1:0]        DUP_LIMIT  = 2'd3;
	localparam logic [CWND_W-1:0] CWND_RESET = 16'd1024;

	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PTR_W = 1;

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_ACK  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_RETX   = 2'd1,
		STAT_DUP    = 2'd2,
		STAT_REJECT = 2'd3
	} status_t;

	typedef struct packed {
		op_t              op;
		logic [SEQ_W-1:0] value;
		logic [LEN_W-1:0] length;
		logic [SUM_W-1:0] sum;
	} cmd_t;

	typedef struct packed {
		logic push;
		cmd_t cmd;
	} cmdq_wr_t;

	typedef struct packed {
		logic avail;
		cmd_t cmd;
	} cmdq_rd_t;

	// Advance a queue pointer by an offset of at most QUEUE_DEPTH, with wrap
	function automatic logic [PTR_W-1:0] ptr_add(logic [PTR_W-1:0] base,
			logic [CNT_W-1:0] offs);
		logic [CNT_W:0] sum;
		sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(offs);
		if (sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
			sum = sum - (CNT_W + 1)'(QUEUE_DEPTH);
		end
		return sum[PTR_W-1:0];
	endfunction

endpackage

FILE: hdl/swat_in_if.sv
// Input channel of the send window ack tracker: valid, ready and one item.
// Depends on swat_pkg for field widths.
interface swat_in_if;
	logic                       valid;
	logic                       ready;
	logic                       command;
	logic [swat_pkg::SEQ_W-1:0] seq_or_ack;
	logic [swat_pkg::LEN_W-1:0] payload_length;

	modport source (output valid, command, seq_or_ack, payload_length, input ready);
	modport sink (input valid, command, seq_or_ack, payload_length, output ready);
endinterface

FILE: hdl/swat_out_if.sv
// Result channel of the send window ack tracker: valid, ready and one result.
// Depends on swat_pkg for field widths.
interface swat_out_if;
	logic                           valid;
	logic                           ready;
	logic [1:0]                     status;
	logic [swat_pkg::SEQ_W-1:0]     window_start;
	logic [swat_pkg::SEQ_W-1:0]     window_end;
	logic [swat_pkg::ENTRIES_W-1:0] entries_held;
	logic [swat_pkg::SEQ_W-1:0]     retransmit_seq;

	modport source (output valid, status, window_start, window_end, entries_held,
		retransmit_seq, input ready);
	modport sink (input valid, status, window_start, window_end, entries_held,
		retransmit_seq, output ready);
endinterface

FILE: hdl/swat_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module swat_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;
endmodule

FILE: hdl/swat_front.sv
// Front end: accept input beats, decode the command, pre-add seq and length.
// Depends on swat_pkg and swat_in_if.
module swat_front (
	swat_in_if.sink          in_ch,
	input  logic             cmdq_full,
	output swat_pkg::cmdq_wr_t cmdq_wr
);
	assign in_ch.ready = !cmdq_full;

	always_comb begin
		cmdq_wr.push       = in_ch.valid && !cmdq_full;
		cmdq_wr.cmd.op     = swat_pkg::op_t'(in_ch.command);
		cmdq_wr.cmd.value  = in_ch.seq_or_ack;
		cmdq_wr.cmd.length = in_ch.payload_length;
		cmdq_wr.cmd.sum    = {1'b0, in_ch.seq_or_ack} + {1'b0, in_ch.payload_length};
	end
endmodule

FILE: hdl/swat_cmd_queue.sv
// Short command queue between the front end and the execution back end.
// Depends on swat_pkg.
module swat_cmd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  swat_pkg::cmdq_wr_t wr,
	output logic               full,
	input  logic               pop,
	output swat_pkg::cmdq_rd_t rd
);
	localparam int CW = swat_pkg::CMDQ_PTR_W + 1;

	swat_pkg::cmd_t                    slot_q [swat_pkg::CMDQ_DEPTH];
	logic [swat_pkg::CMDQ_PTR_W-1:0]   wr_ptr_q;
	logic [swat_pkg::CMDQ_PTR_W-1:0]   rd_ptr_q;
	logic [CW-1:0]                     count_q;
	logic                              do_push;
	logic                              do_pop;

	assign full     = (count_q == CW'(swat_pkg::CMDQ_DEPTH));
	assign rd.avail = (count_q != '0);
	assign rd.cmd   = slot_q[rd_ptr_q];
	assign do_push  = wr.push && !full;
	assign do_pop   = pop && rd.avail;

	function automatic logic [swat_pkg::CMDQ_PTR_W-1:0] bump(
			logic [swat_pkg::CMDQ_PTR_W-1:0] p);
		if (p == swat_pkg::CMDQ_PTR_W'(swat_pkg::CMDQ_DEPTH - 1)) begin
			return '0;
		end
		return p + swat_pkg::CMDQ_PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wr.cmd;
		end
	end
endmodule

FILE: hdl/swat_back.sv
// Back end: run push and ack commands against the segment queue and emit results.
// Depends on swat_pkg and swat_out_if; drives the entry RAM ports.
module swat_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [swat_pkg::CWND_W-1:0]    cwnd,
	input  swat_pkg::cmdq_rd_t             cmdq_rd,
	output logic                           cmdq_pop,
	output logic                           ram_wr_en,
	output logic [swat_pkg::PTR_W-1:0]     ram_wr_addr,
	output logic [swat_pkg::ENTRY_W-1:0]   ram_wr_data,
	output logic [swat_pkg::PTR_W-1:0]     ram_rd_addr,
	input  logic [swat_pkg::ENTRY_W-1:0]   ram_rd_data,
	swat_out_if.source                     out_ch
);
	localparam int SEQ_W = swat_pkg::SEQ_W;
	localparam int CNT_W = swat_pkg::CNT_W;
	localparam int SUM_W = swat_pkg::SUM_W;
	localparam int K_W   = swat_pkg::K_W;
	localparam logic [SUM_W:0] MOD_EXT = (SUM_W + 1)'(swat_pkg::SEQ_MODULUS);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_MOD    = 7'b0000010,
		ST_FLIGHT = 7'b0000100,
		ST_CHECK  = 7'b0001000,
		ST_SCAN   = 7'b0010000,
		ST_HEAD   = 7'b0100000,
		ST_DONE   = 7'b1000000
	} state_t;

	state_t                       state_q;
	swat_pkg::cmd_t               cmd_q;
	swat_pkg::status_t            status_q;
	logic [CNT_W-1:0]             occ_q;
	logic [swat_pkg::PTR_W-1:0]   head_q;
	logic [SEQ_W-1:0]             head_start_q;
	logic [1:0]                   dup_q;
	logic [SEQ_W-1:0]             start_q;
	logic [SEQ_W-1:0]             end_q;
	logic [SUM_W:0]               rem_q;
	logic [K_W-1:0]               k_q;
	logic [SEQ_W-1:0]             flight_q;
	logic [CNT_W-1:0]             scan_idx_q;
	logic                         out_valid_q;
	swat_pkg::status_t            out_status_q;
	logic [SEQ_W-1:0]             out_start_q;
	logic [SEQ_W-1:0]             out_end_q;
	logic [swat_pkg::ENTRIES_W-1:0] out_entries_q;
	logic [SEQ_W-1:0]             out_retx_q;

	logic [SUM_W:0]               mod_shifted;
	logic [SEQ_W:0]               wrap_sum;
	logic [SEQ_W-1:0]             flight_next;
	logic                         fits;
	logic                         room;
	logic [CNT_W-1:0]             drop_cnt;
	logic [swat_pkg::PTR_W-1:0]   scan_ptr;
	logic [SEQ_W-1:0]             rd_start;
	logic [SEQ_W-1:0]             rd_expected;
	logic [1:0]                   dup_next;
	logic                         out_free;

	assign mod_shifted = MOD_EXT << k_q;
	assign wrap_sum    = (SEQ_W + 1)'(swat_pkg::SEQ_MODULUS) - {1'b0, head_start_q}
		+ {1'b0, end_q};
	assign flight_next = (occ_q == '0) ? '0 :
		(head_start_q > end_q) ? wrap_sum[SEQ_W-1:0] : (end_q - head_start_q);
	assign fits = ({1'b0, flight_q} + {1'b0, cmd_q.length}) <= {1'b0, cwnd};
	assign room = occ_q < CNT_W'(swat_pkg::QUEUE_DEPTH);

	assign drop_cnt    = scan_idx_q + CNT_W'(1);
	assign scan_ptr    = swat_pkg::ptr_add(head_q, drop_cnt);
	assign rd_start    = ram_rd_data[swat_pkg::ENTRY_W-1:SEQ_W];
	assign rd_expected = ram_rd_data[SEQ_W-1:0];
	assign dup_next    = (dup_q == swat_pkg::DUP_LIMIT) ? dup_q : dup_q + 2'd1;
	assign out_free    = !out_valid_q || out_ch.ready;

	assign cmdq_pop    = (state_q == ST_IDLE) && cmdq_rd.avail;
	assign ram_rd_addr = (state_q == ST_SCAN) ? scan_ptr : head_q;
	assign ram_wr_en   = (state_q == ST_CHECK) && fits && room;
	assign ram_wr_addr = swat_pkg::ptr_add(head_q, occ_q);
	assign ram_wr_data = {cmd_q.value, rem_q[SEQ_W-1:0]};

	assign out_ch.valid          = out_valid_q;
	assign out_ch.status         = out_status_q;
	assign out_ch.window_start   = out_start_q;
	assign out_ch.window_end     = out_end_q;
	assign out_ch.entries_held   = out_entries_q;
	assign out_ch.retransmit_seq = out_retx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cmd_q         <= '0;
			status_q      <= swat_pkg::STAT_OK;
			occ_q         <= '0;
			head_q        <= '0;
			head_start_q  <= '0;
			dup_q         <= '0;
			start_q       <= '0;
			end_q         <= '0;
			rem_q         <= '0;
			k_q           <= '0;
			flight_q      <= '0;
			scan_idx_q    <= '0;
			out_valid_q   <= 1'b0;
			out_status_q  <= swat_pkg::STAT_OK;
			out_start_q   <= '0;
			out_end_q     <= '0;
			out_entries_q <= '0;
			out_retx_q    <= '0;
		end else begin
			// Drop a taken result; DONE reloads the register itself
			if (out_valid_q && out_ch.ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmdq_rd.avail) begin
						cmd_q      <= cmdq_rd.cmd;
						rem_q      <= (SUM_W + 1)'(cmdq_rd.cmd.sum);
						k_q        <= K_W'(swat_pkg::K_MAX);
						scan_idx_q <= '0;
						if (cmdq_rd.cmd.op == swat_pkg::OP_PUSH) begin
							state_q <= ST_MOD;
						end else if (occ_q == '0) begin
							status_q <= swat_pkg::STAT_REJECT;
							state_q  <= ST_DONE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_MOD: begin
					if (rem_q >= mod_shifted) begin
						rem_q <= rem_q - mod_shifted;
					end
					if (k_q == '0) begin
						state_q <= ST_FLIGHT;
					end else begin
						k_q <= k_q - K_W'(1);
					end
				end
				ST_FLIGHT: begin
					flight_q <= flight_next;
					state_q  <= ST_CHECK;
				end
				ST_CHECK: begin
					if (fits && room) begin
						end_q <= rem_q[SEQ_W-1:0];
						occ_q <= occ_q + CNT_W'(1);
						if (occ_q == '0) begin
							head_start_q <= cmd_q.value;
							start_q      <= cmd_q.value;
							dup_q        <= '0;
						end else begin
							start_q <= head_start_q;
						end
						status_q <= swat_pkg::STAT_OK;
					end else begin
						status_q <= swat_pkg::STAT_REJECT;
					end
					state_q <= ST_DONE;
				end
				ST_SCAN: begin
					if (rd_expected == cmd_q.value) begin
						occ_q    <= occ_q - drop_cnt;
						head_q   <= scan_ptr;
						start_q  <= cmd_q.value;
						dup_q    <= '0;
						status_q <= swat_pkg::STAT_OK;
						state_q  <= (occ_q != drop_cnt) ? ST_HEAD : ST_DONE;
					end else if (drop_cnt == occ_q) begin
						if (head_start_q == cmd_q.value) begin
							dup_q    <= dup_next;
							status_q <= (dup_next == swat_pkg::DUP_LIMIT) ?
								swat_pkg::STAT_RETX : swat_pkg::STAT_DUP;
						end else begin
							status_q <= swat_pkg::STAT_REJECT;
						end
						state_q <= ST_DONE;
					end else begin
						scan_idx_q <= drop_cnt;
					end
				end
				ST_HEAD: begin
					head_start_q <= rd_start;
					state_q      <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q   <= 1'b1;
						out_status_q  <= status_q;
						out_start_q   <= start_q;
						out_end_q     <= end_q;
						out_entries_q <= swat_pkg::ENTRIES_W'(occ_q);
						out_retx_q    <= (occ_q != '0) ? head_start_q : '0;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

FILE: hdl/send_window_ack_tracker_core.sv
// Send window ack tracker. A push goes through pop, 3 remainder steps, flight count,
// window check and result load; an ack with entries held goes through pop, a walk of
// the held entries at one entry RAM read a cycle, a fetch of the new front after a
// partial cut, and result load. One command is in the back end at a time; the two-slot
// command queue and the result register let either side stall alone. Reset clears all
// state but the entry RAM and the command queue slots; congestion window 1024.
module send_window_ack_tracker_core (
	input  logic                        clk,
	input  logic                        arst_n,
	swat_in_if.sink                     in_ch,
	swat_out_if.source                  out_ch,
	input  logic                        cfg_write_enable,
	input  logic [swat_pkg::CWND_W-1:0] cfg_write_data
);
	// Congestion window; the user must write it only while the block is idle (not enforced)
	logic [swat_pkg::CWND_W-1:0] cwnd_q;

	swat_pkg::cmdq_wr_t           cmdq_wr;
	swat_pkg::cmdq_rd_t           cmdq_rd;
	logic                         cmdq_full;
	logic                         cmdq_pop;
	logic                         ram_wr_en;
	logic [swat_pkg::PTR_W-1:0]   ram_wr_addr;
	logic [swat_pkg::ENTRY_W-1:0] ram_wr_data;
	logic [swat_pkg::PTR_W-1:0]   ram_rd_addr;
	logic [swat_pkg::ENTRY_W-1:0] ram_rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cwnd_q <= swat_pkg::CWND_RESET;
		end else if (cfg_write_enable) begin
			cwnd_q <= cfg_write_data;
		end
	end

	// Front: take beats while the queue has room, decode and pre-add
	swat_front u_front (
		.in_ch     (in_ch),
		.cmdq_full (cmdq_full),
		.cmdq_wr   (cmdq_wr)
	);

	// Hold decoded commands until the back end is free
	swat_cmd_queue u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cmdq_wr),
		.full   (cmdq_full),
		.pop    (cmdq_pop),
		.rd     (cmdq_rd)
	);

	// Segment entries kept as a ring: {start seq, expected ack} per slot.
	// The front entry's start and dup count live in back-end registers.
	swat_ram #(
		.WIDTH (swat_pkg::ENTRY_W),
		.DEPTH (swat_pkg::QUEUE_DEPTH)
	) u_entry_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// Back: reduce, check the window, walk the ring for acks, drop acked entries
	swat_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cwnd        (cwnd_q),
		.cmdq_rd     (cmdq_rd),
		.cmdq_pop    (cmdq_pop),
		.ram_wr_en   (ram_wr_en),
		.ram_wr_addr (ram_wr_addr),
		.ram_wr_data (ram_wr_data),
		.ram_rd_addr (ram_rd_addr),
		.ram_rd_data (ram_rd_data),
		.out_ch      (out_ch)
	);
endmodule

FILE: bench/swat_window_checker.sv
// Scoreboard for the send window ack tracker: watches both channels and the
// window register port, predicts every result and compares it field by field.
// Depends on swat_pkg, swat_in_if and swat_out_if.
module swat_window_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	swat_in_if                          in_mon,
	swat_out_if                         out_mon,
	input  logic                        cfg_write_enable,
	input  logic [swat_pkg::CWND_W-1:0] cfg_write_data,
	output int                          mismatches,
	output int                          results_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import swat_pkg::*;

	typedef struct packed {
		status_t                status;
		logic [SEQ_W-1:0]       win_start;
		logic [SEQ_W-1:0]       win_end;
		logic [ENTRIES_W-1:0]   held;
		logic [SEQ_W-1:0]       oldest_seq;
	} window_result_t;

	// Tracked window: unacked segments oldest first
	logic [SEQ_W-1:0]  seg_start [QUEUE_DEPTH];
	logic [SEQ_W-1:0]  seg_ack [QUEUE_DEPTH];
	logic [1:0]        seg_dups [QUEUE_DEPTH];
	int unsigned       seg_count;
	logic [SEQ_W-1:0]  win_start;
	logic [SEQ_W-1:0]  win_end;
	logic [CWND_W-1:0] cwnd;

	window_result_t window_results [$];
	window_result_t want;
	int             fail_total = 0;
	int             results_seen = 0;

	function automatic window_result_t advance_window(op_t op, logic [SEQ_W-1:0] value,
			logic [LEN_W-1:0] length);
		window_result_t r;
		int unsigned    first;
		int unsigned    in_flight;
		int unsigned    ack_at;
		int unsigned    k;
		bit             matched;
		r.status = STAT_REJECT;
		case (op)
			OP_PUSH: begin
				in_flight = 0;
				if (seg_count != 0) begin
					first = seg_start[0];
					if (first > win_end) begin
						in_flight = (SEQ_MODULUS - first + win_end) & 32'hFFFF;
					end else begin
						in_flight = win_end - first;
					end
				end
				if (seg_count < QUEUE_DEPTH && in_flight + length <= cwnd) begin
					seg_start[seg_count] = value;
					seg_ack[seg_count] = SEQ_W'((32'(value) + 32'(length)) % SEQ_MODULUS);
					seg_dups[seg_count] = 2'd0;
					seg_count++;
					win_end = seg_ack[seg_count-1];
					win_start = seg_start[0];
					r.status = STAT_OK;
				end
			end
			OP_ACK: begin
				if (seg_count != 0) begin
					matched = 1'b0;
					ack_at = 0;
					for (k = 0; k < seg_count && !matched; k++) begin
						if (seg_ack[k] == value) begin
							matched = 1'b1;
							ack_at = k;
						end
					end
					if (matched) begin
						// drop everything through the acked segment
						win_start = seg_ack[ack_at];
						for (k = 0; k + ack_at + 1 < seg_count; k++) begin
							seg_start[k] = seg_start[k+ack_at+1];
							seg_ack[k] = seg_ack[k+ack_at+1];
							seg_dups[k] = seg_dups[k+ack_at+1];
						end
						seg_count -= ack_at + 1;
						r.status = STAT_OK;
					end else if (seg_start[0] == value) begin
						if (seg_dups[0] != DUP_LIMIT) begin
							seg_dups[0]++;
						end
						r.status = (seg_dups[0] == DUP_LIMIT) ? STAT_RETX : STAT_DUP;
					end
				end
			end
		endcase
		r.win_start = win_start;
		r.win_end = win_end;
		r.held = ENTRIES_W'(seg_count);
		r.oldest_seq = (seg_count != 0) ? seg_start[0] : '0;
		return r;
	endfunction

	task automatic report_mismatch(input string field, input logic [SEQ_W-1:0] got,
			input logic [SEQ_W-1:0] expected);
		if (fail_total < 100) begin
			$display("%0t: result %0d %s got %h expected %h", $time, results_seen, field,
				got, expected);
		end
		fail_total++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_count = 0;
			win_start = '0;
			win_end = '0;
			cwnd = CWND_RESET;
			window_results.delete();
			results_pending <= 0;
			mismatches <= 0;
		end else begin
			if (cfg_write_enable) begin
				cwnd = cfg_write_data;
			end
			if (out_mon.valid && out_mon.ready) begin
				if (window_results.size() == 0) begin
					report_mismatch("unexpected beat, status", SEQ_W'(out_mon.status), '0);
				end else begin
					want = window_results.pop_front();
					if (out_mon.status !== want.status)
						report_mismatch("status", SEQ_W'(out_mon.status),
							SEQ_W'(want.status));
					if (out_mon.window_start !== want.win_start)
						report_mismatch("window_start", out_mon.window_start, want.win_start);
					if (out_mon.window_end !== want.win_end)
						report_mismatch("window_end", out_mon.window_end, want.win_end);
					if (out_mon.entries_held !== want.held)
						report_mismatch("entries_held", SEQ_W'(out_mon.entries_held),
							SEQ_W'(want.held));
					if (out_mon.retransmit_seq !== want.oldest_seq)
						report_mismatch("retransmit_seq", out_mon.retransmit_seq,
							want.oldest_seq);
				end
				results_seen++;
			end
			if (in_mon.valid && in_mon.ready) begin
				window_results.insert(window_results.size(),
					advance_window(op_t'(in_mon.command), in_mon.seq_or_ack,
					in_mon.payload_length));
			end
			results_pending <= window_results.size();
			mismatches <= fail_total;
		end
	end

endmodule

FILE: bench/send_window_ack_tracker_core_tb.sv
// Top of the send window ack tracker bench: clock, reset, stimulus, result
// back-pressure and verdict. Depends on swat_pkg, both channel interfaces,
// send_window_ack_tracker_core and swat_window_checker.
module send_window_ack_tracker_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import swat_pkg::*;

	// Slowest legal run: ~1400 beats, each with its time in the block plus
	// a long sender gap and a long receiver stall, plus two result hold-offs.
	// CYCLE_LIMIT allows several times that.
	localparam int          CYCLE_LIMIT = 1_000_000;
	localparam int unsigned PHASE_ITEMS = 205;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_write_enable;
	logic [CWND_W-1:0] cfg_write_data;
	int                mismatches;
	int                results_pending;
	int                cycle_count = 0;

	// Sender bookkeeping: the segment stream we have offered so far, oldest first.
	// It may hold segments the block refused; acks of those just get rejected.
	bit                sender_gaps = 1'b1;
	logic [CWND_W-1:0] cwnd_now = CWND_RESET;
	logic [SEQ_W-1:0]  next_seq;
	logic [SEQ_W-1:0]  sent_start [$];
	logic [SEQ_W-1:0]  sent_end [$];

	swat_in_if  in_ch ();
	swat_out_if out_ch ();

	send_window_ack_tracker_core i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_ch            (in_ch),
		.out_ch           (out_ch),
		.cfg_write_enable (cfg_write_enable),
		.cfg_write_data   (cfg_write_data)
	);

	swat_window_checker i_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_mon           (in_ch),
		.out_mon          (out_ch),
		.cfg_write_enable (cfg_write_enable),
		.cfg_write_data   (cfg_write_data),
		.mismatches       (mismatches),
		.results_pending  (results_pending)
	);

	always #1 clk = ~clk;

	// Watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Idle length: mostly none or short, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Segment length scaled to the current window so that most pushes fit
	// and the queue can fill; some overflow the window, a few are arbitrary.
	function automatic logic [LEN_W-1:0] pick_length();
		int unsigned r;
		int unsigned lim;
		r = $urandom_range(0, 99);
		lim = cwnd_now / 6;
		if (lim > 2000) lim = 2000;
		if (r < 80) return LEN_W'($urandom_range(0, lim));
		if (r < 95) return LEN_W'($urandom_range(0, cwnd_now));
		return LEN_W'($urandom);
	endfunction

	// Offer one beat, maybe after an idle gap, and hold it until accepted.
	// valid stays high across back-to-back beats.
	task automatic send_beat(op_t op, logic [SEQ_W-1:0] value, logic [LEN_W-1:0] length);
		int unsigned gap;
		gap = sender_gaps ? pick_gap() : 0;
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.command <= op;
		in_ch.seq_or_ack <= value;
		in_ch.payload_length <= length;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	// Drop valid and hold until every predicted result has been taken
	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (results_pending != 0);
	endtask

	// Change the congestion window only with nothing in flight
	task automatic write_cwnd(logic [CWND_W-1:0] value);
		wait_idle();
		cfg_write_enable <= 1'b1;
		cfg_write_data <= value;
		@(posedge clk);
		cfg_write_enable <= 1'b0;
		cwnd_now = value;
	endtask

	// One random step of a plausible sender: push the next segment, ack through
	// an outstanding one, repeat the front start as duplicates, send near misses, or throw noise.
	task automatic random_item();
		int unsigned      pick;
		int unsigned      k;
		logic [SEQ_W-1:0] seq;
		logic [LEN_W-1:0] length;
		logic [SEQ_W-1:0] ack_value;
		pick = $urandom_range(0, 99);
		if (sent_end.size() == 0 && pick < 85) pick = 0;
		if (pick < 45) begin
			length = pick_length();
			seq = next_seq;
			next_seq = SEQ_W'((32'(seq) + 32'(length)) % SEQ_MODULUS);
			sent_start.insert(sent_start.size(), seq);
			sent_end.insert(sent_end.size(), next_seq);
			if (sent_end.size() > 24) begin
				void'(sent_start.pop_front());
				void'(sent_end.pop_front());
			end
			send_beat(OP_PUSH, seq, length);
		end else if (pick < 70) begin
			// cumulative ack, often of the oldest segment
			k = ($urandom_range(0, 1) != 0) ? $urandom_range(0, sent_end.size() - 1) : 0;
			ack_value = sent_end[k];
			repeat (k + 1) begin
				void'(sent_start.pop_front());
				void'(sent_end.pop_front());
			end
			send_beat(OP_ACK, ack_value, LEN_W'($urandom));
		end else if (pick < 80) begin
			// burst of duplicates at the window front
			repeat ($urandom_range(1, 4)) send_beat(OP_ACK, sent_start[0], LEN_W'($urandom));
		end else if (pick < 85) begin
			// near misses: a later start, or one past an expected ack
			k = $urandom_range(0, sent_end.size() - 1);
			ack_value = ($urandom_range(0, 1) != 0) ? sent_start[k] : sent_end[k] + 1'b1;
			send_beat(OP_ACK, ack_value, LEN_W'($urandom));
		end else begin
			send_beat(op_t'(1'($urandom)), SEQ_W'($urandom), LEN_W'($urandom));
		end
	endtask

	// Result side: random stalls whose density is redrawn at each reload of mode_left,
	// and a hold-off after 300 beats and every 700 beats after that, so the block backs up
	// into its input while the sender keeps offering.
	initial begin
		int unsigned beats_taken;
		int unsigned next_hold_at;
		int unsigned hold_left;
		int unsigned stall_left;
		int unsigned mode_left;
		int unsigned stall_pct;
		beats_taken = 0;
		next_hold_at = 300;
		hold_left = 0;
		stall_left = 0;
		mode_left = 0;
		stall_pct = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready) beats_taken++;
			if (mode_left == 0) begin
				mode_left = 300;
				case ($urandom_range(0, 2))
					0: stall_pct = 0;
					1: stall_pct = 30;
					default: stall_pct = 70;
				endcase
			end
			mode_left--;
			if (hold_left == 0 && beats_taken >= next_hold_at) begin
				hold_left = 400;
				next_hold_at += 700;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
				if ($urandom_range(0, 99) < stall_pct) stall_left = pick_gap();
			end
		end
	end

	initial begin
		logic [CWND_W-1:0] cwnd_plan [6];
		int unsigned       phase;
		int unsigned       n;
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.command <= OP_PUSH;
		in_ch.seq_or_ack <= '0;
		in_ch.payload_length <= '0;
		cfg_write_enable <= 1'b0;
		cfg_write_data <= '0;
		// window extremes first, then ordinary and tight settings
		cwnd_plan = '{16'hFFFF, 16'd0, 16'd1024, CWND_W'($urandom_range(1, 65534)),
			16'd4096, 16'd300};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, window at its reset value of 1024.
		// Ack with nothing held is refused.
		send_beat(OP_ACK, 16'd0, 16'd0);
		// Zero-length segment: its ack equals its start, and the match wins.
		send_beat(OP_PUSH, 16'd0, 16'd0);
		send_beat(OP_ACK, 16'd0, 16'hFFFF);
		// Largest seq and length: far over the window.
		send_beat(OP_PUSH, 16'hFFFF, 16'hFFFF);
		// Segment crossing the sequence wrap, then one after it.
		send_beat(OP_PUSH, 16'd30719, 16'd100);
		send_beat(OP_PUSH, 16'd99, 16'd200);
		// Four duplicates: two plain, then retransmit, then saturated.
		repeat (4) send_beat(OP_ACK, 16'd30719, 16'd0);
		// Ack that matches nothing.
		send_beat(OP_ACK, 16'd12345, 16'd0);
		// Cumulative ack of the newer segment clears both.
		send_beat(OP_ACK, 16'd299, 16'd0);
		// Start above the sequence space: stored raw, ack reduced.
		send_beat(OP_PUSH, 16'd50000, 16'd10);
		send_beat(OP_PUSH, 16'd19290, 16'd5);
		send_beat(OP_ACK, 16'd50000, 16'd0);
		send_beat(OP_ACK, 16'd19295, 16'd0);
		// Exactly a full window fits; one byte more does not.
		send_beat(OP_PUSH, 16'd19295, 16'd1024);
		send_beat(OP_PUSH, 16'd20319, 16'd1);
		send_beat(OP_ACK, 16'd20319, 16'd0);
		next_seq = 16'd20319;

		// Random phases, one window setting each. Halfway through each phase
		// pause until the block has drained; some phases send back to back.
		for (phase = 0; phase < 6; phase++) begin
			write_cwnd(cwnd_plan[phase]);
			sender_gaps = (phase % 3) != 2;
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (n == PHASE_ITEMS / 2) wait_idle();
				random_item();
			end
		end

		// Drain, then give the block time to show any stray result
		wait_idle();
		repeat (40) @(posedge clk);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
